/* rtl/dnsa_pkg.sv */
package dnsa_pkg;

  // Frame limits
  localparam int unsigned MIN_FRAME_BYTES = 64;
  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned QUESTION_LIMIT  = 300;
  localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES);
  // Walk can run one label (up to 256 bytes) past the limit, then 5 more
  localparam int unsigned LABEL_W         = $clog2(QUESTION_LIMIT + 261);

  // Header field values
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  POINTER_BYTE   = 8'hC0;
  localparam logic [3:0]  MIN_IHL_WORDS  = 4'd5;

  // Register reset values
  localparam logic [15:0] TXID_RESET        = 16'd8721;
  localparam logic [31:0] SERVER_ADDR_RESET = 32'd167772675;
  localparam logic [15:0] CLIENT_PORT_RESET = 16'd43210;
  localparam logic [15:0] SERVER_PORT_RESET = 16'd53;

  typedef enum logic [1:0] {
    REG_EXPECTED_TXID  = 2'd0,
    REG_SERVER_ADDRESS = 2'd1,
    REG_CLIENT_PORT    = 2'd2,
    REG_SERVER_PORT    = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_RESOLVED    = 3'd0,
    ST_IGNORED     = 3'd1,
    ST_NO_ANSWER   = 3'd2,
    ST_NOT_POINTER = 3'd3,
    ST_NOT_A       = 3'd4
  } status_t;

endpackage

/* rtl/dnsa_if.sv */
interface dnsa_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_last;

  modport source (output valid, output rx_byte, output frame_last, input ready);
  modport sink   (input valid, input rx_byte, input frame_last, output ready);
endinterface

interface dnsa_verdict_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] resolved_address;

  modport source (output valid, output status, output resolved_address, input ready);
  modport sink   (input valid, input status, input resolved_address, output ready);
endinterface

/* rtl/dns_a_response_parser.sv */
// Channel   Dir  Payload                          Item
// rx        in   rx_byte[7:0], frame_last         one frame byte
// verdict   out  status[2:0], resolved_address    one verdict per frame
// cfg       in   cfg_we, cfg_index[1:0], cfg_data one register write
//
// Throughput is one byte per cycle while no verdict stall applies; each byte
// passes the input register, and its frame's verdict goes to the output register.
// The parse is a single pass of position compares against the byte counter.
// rst is synchronous, active high; it restores register defaults and clears
// the frame state. A verdict waiting on verdict.ready holds the following
// frame's last byte in the input register, and the input with it; the
// earlier bytes of that frame keep flowing.
module dns_a_response_parser (
  input  logic                   clk,
  input  logic                   rst,
  dnsa_byte_if.sink              rx,
  dnsa_verdict_if.source         verdict,
  input  logic                   cfg_we,
  input  dnsa_pkg::reg_index_t   cfg_index,
  input  logic [31:0]            cfg_data
);
  import dnsa_pkg::*;

  // Configuration registers
  logic [15:0] expected_txid;
  logic [31:0] server_address;
  logic [15:0] client_port;
  logic [15:0] server_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_txid  <= TXID_RESET;
      server_address <= SERVER_ADDR_RESET;
      client_port    <= CLIENT_PORT_RESET;
      server_port    <= SERVER_PORT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPECTED_TXID:  expected_txid  <= cfg_data[15:0];
        REG_SERVER_ADDRESS: server_address <= cfg_data;
        REG_CLIENT_PORT:    client_port    <= cfg_data[15:0];
        REG_SERVER_PORT:    server_port    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_advance;

  // Output register
  logic        out_valid;
  status_t     out_status;
  logic [31:0] out_addr;

  // A last byte may only move on when the output register is free
  assign s1_advance = s1_valid && (!s1_last || !out_valid || verdict.ready);
  assign rx.ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.rx_byte;
      s1_last <= rx.frame_last;
    end
  end

  // Per-frame parse state
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [5:0]         header_bytes, header_bytes_next;
  logic               frame_rejected, frame_rejected_next;
  status_t            verdict_code, verdict_code_next;
  logic [LABEL_W-1:0] next_label_position, next_label_position_next;
  logic [LABEL_W-1:0] answer_position, answer_position_next;
  logic [7:0]         prev_byte;
  logic               type_ok, type_ok_next;
  logic               class_ok, class_ok_next;
  logic [31:0]        address_accumulator, address_accumulator_next;

  logic [15:0]        field;      // previous byte and this one, big endian
  logic [6:0]         dns_start;  // offset of the DNS header in the frame
  logic [POS_W-1:0]   udp_src_end, udp_dst_end, rel;
  logic [LABEL_W-1:0] label_q, label_nq;
  logic [POS_W-1:0]   ans;
  logic [7:0]         addr_byte;
  status_t            final_status;

  always_comb begin
    field       = {prev_byte, s1_byte};
    dns_start   = 7'd22 + 7'(header_bytes);
    udp_src_end = POS_W'(dns_start) - POS_W'(7);
    udp_dst_end = POS_W'(dns_start) - POS_W'(5);
    rel         = byte_position - POS_W'(dns_start);
    label_q     = next_label_position + LABEL_W'(12);
    label_nq    = label_q + LABEL_W'(s1_byte) + LABEL_W'(1);
    ans         = POS_W'(answer_position);

    unique case (byte_position[1:0])
      2'b10:   addr_byte = server_address[31:24];
      2'b11:   addr_byte = server_address[23:16];
      2'b00:   addr_byte = server_address[15:8];
      default: addr_byte = server_address[7:0];
    endcase

    header_bytes_next        = header_bytes;
    frame_rejected_next      = frame_rejected;
    verdict_code_next        = verdict_code;
    next_label_position_next = next_label_position;
    answer_position_next     = answer_position;
    type_ok_next             = type_ok;
    class_ok_next            = class_ok;
    address_accumulator_next = address_accumulator;

    // Once rejected or decided, later bytes are don't-care
    if (!frame_rejected && verdict_code == ST_IGNORED) begin
      if (byte_position == POS_W'(13)) begin
        if (field != ETHERTYPE_IPV4) frame_rejected_next = 1'b1;
      end else if (byte_position == POS_W'(14)) begin
        header_bytes_next = {s1_byte[3:0], 2'b00};
        if (s1_byte[3:0] < MIN_IHL_WORDS) frame_rejected_next = 1'b1;
      end else if (byte_position < POS_W'(14)) begin
      end else if (byte_position == POS_W'(23)) begin
        if (s1_byte != PROTO_UDP) frame_rejected_next = 1'b1;
      end else if (byte_position >= POS_W'(26) && byte_position <= POS_W'(29)) begin
        if (addr_byte != s1_byte) frame_rejected_next = 1'b1;
      end else if (byte_position == udp_src_end) begin
        if (field != server_port) frame_rejected_next = 1'b1;
      end else if (byte_position == udp_dst_end) begin
        if (field != client_port) frame_rejected_next = 1'b1;
      end else if (byte_position < POS_W'(dns_start)) begin
      end else if (rel == POS_W'(1)) begin
        if (field != expected_txid) frame_rejected_next = 1'b1;
      end else if (rel == POS_W'(7)) begin
        if (field == 16'd0) verdict_code_next = ST_NO_ANSWER;
      end else if (answer_position == '0) begin
        // Question label walk
        if (rel == POS_W'(label_q)) begin
          if (s1_byte == 8'd0) begin
            answer_position_next = label_q + LABEL_W'(5);
          end else if (label_nq >= LABEL_W'(QUESTION_LIMIT)) begin
            answer_position_next = label_nq + LABEL_W'(5);
          end else begin
            next_label_position_next = label_nq - LABEL_W'(12);
          end
        end
      end else begin
        if (rel == ans) begin
          if (s1_byte != POINTER_BYTE) verdict_code_next = ST_NOT_POINTER;
        end else if (rel == ans + POS_W'(3)) begin
          type_ok_next = (field == 16'd1);
        end else if (rel == ans + POS_W'(5)) begin
          class_ok_next = (field == 16'd1);
        end else if (rel == ans + POS_W'(11)) begin
          if (!(type_ok && class_ok && field == 16'd4)) verdict_code_next = ST_NOT_A;
        end else if (rel >= ans + POS_W'(12) && rel <= ans + POS_W'(15)) begin
          address_accumulator_next = {address_accumulator[23:0], s1_byte};
          if (rel == ans + POS_W'(15)) verdict_code_next = ST_RESOLVED;
        end
      end
    end

    if (frame_rejected_next || byte_position < POS_W'(MIN_FRAME_BYTES - 1)) begin
      final_status = ST_IGNORED;
    end else begin
      final_status = verdict_code_next;
    end

    // Position holds at the top; an oversize frame is dropped
    byte_position_next = byte_position;
    if (byte_position >= POS_W'(MAX_FRAME_BYTES - 1)) begin
      frame_rejected_next = 1'b1;
    end else begin
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_advance && s1_last)) begin
      byte_position       <= '0;
      header_bytes        <= '0;
      frame_rejected      <= 1'b0;
      verdict_code        <= ST_IGNORED;
      next_label_position <= '0;
      answer_position     <= '0;
      prev_byte           <= '0;
      type_ok             <= 1'b0;
      class_ok            <= 1'b0;
      address_accumulator <= '0;
    end else if (s1_advance) begin
      byte_position       <= byte_position_next;
      header_bytes        <= header_bytes_next;
      frame_rejected      <= frame_rejected_next;
      verdict_code        <= verdict_code_next;
      next_label_position <= next_label_position_next;
      answer_position     <= answer_position_next;
      prev_byte           <= s1_byte;
      type_ok             <= type_ok_next;
      class_ok            <= class_ok_next;
      address_accumulator <= address_accumulator_next;
    end
  end

  // Verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      out_status <= final_status;
      out_addr   <= (final_status == ST_RESOLVED) ? address_accumulator_next : 32'd0;
    end
  end

  assign verdict.valid            = out_valid;
  assign verdict.status           = out_status;
  assign verdict.resolved_address = out_addr;

  // Checks
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_RESOLVED |-> out_addr == 32'd0)
    else $error("address not zero on unresolved verdict");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_last |=> byte_position == '0 && verdict_code == ST_IGNORED)
    else $error("frame state not cleared after last byte");

  a_verdict_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !verdict.ready |=> out_valid && $stable(out_status) && $stable(out_addr))
    else $error("pending verdict lost");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("stalled byte lost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !verdict.ready |-> !(s1_advance && s1_last))
    else $error("verdict overwritten");

endmodule

/* tb/tb_top.sv */
module tb_top;
  import dnsa_pkg::*;

  // Hard stop, in time units; the clock period is 4 units.
  localparam int unsigned RUN_LIMIT = 4_000_000;

  // Fixed frame offsets (Ethernet + IPv4) used by the parser.
  localparam int unsigned ETH_TYPE_HI = 12;
  localparam int unsigned ETH_TYPE_LO = 13;
  localparam int unsigned ETH_HDR     = 14;  // also the IP version/IHL byte
  localparam int unsigned IP_PROTO    = 23;
  localparam int unsigned IP_SRC      = 26;
  localparam int unsigned MIN_IP_HDR  = 4 * MIN_IHL_WORDS;

  // DNS offsets relative to the start of the DNS header.
  localparam int unsigned DNS_TXID_LO  = 1;
  localparam int unsigned DNS_ANCNT_LO = 7;
  localparam int unsigned DNS_QUESTION = 12;

  // Answer record values that make a usable A record.
  localparam logic [15:0] TYPE_A   = 16'd1;
  localparam logic [15:0] CLASS_IN = 16'd1;
  localparam logic [15:0] A_RDLEN  = 16'd4;

  // One thing wrong with an otherwise good reply.
  typedef enum {
    DEF_NONE,
    DEF_ETHERTYPE,
    DEF_PROTO,
    DEF_SOURCE,
    DEF_SPORT,
    DEF_DPORT,
    DEF_TXID,
    DEF_SHORT_IHL,
    DEF_NO_ANSWER,
    DEF_NAME,
    DEF_TYPE,
    DEF_CLASS,
    DEF_RDLEN,
    DEF_EARLY_END
  } defect_t;

  // Knobs for building one reply frame.
  typedef struct {
    logic [3:0]  ihl;
    logic [15:0] ancount;
    logic [7:0]  name_byte;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] rdlen;
    logic [31:0] addr;
    int unsigned n_labels;
    int unsigned max_label;
    int unsigned tail;
  } reply_t;

  typedef struct {
    status_t     status;
    logic [31:0] address;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  reg_index_t  cfg_index;
  logic [31:0] cfg_data;

  dnsa_byte_if    rx();
  dnsa_verdict_if verdict();

  dns_a_response_parser dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .verdict   (verdict),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Parser tracking: register copies and per-frame parse state
  // ---------------------------------------------------------------------
  logic [15:0] txid_reg, cport_reg, sport_reg;
  logic [31:0] server_reg;

  int unsigned byte_pos;
  int unsigned ip_hdr_len;
  int unsigned next_label;   // DNS offset of the next question label
  int unsigned answer_pos;   // DNS offset of the answer, 0 while walking
  logic        rejected;
  status_t     decided;      // ST_IGNORED doubles as "not decided yet"
  logic [15:0] last_two;
  logic [15:0] an_count, rr_type, rr_class, rr_len;
  logic [31:0] addr_acc;

  verdict_t expected_verdicts[$];
  int       mismatches = 0;

  // Stimulus shaping
  logic        rx_gaps_on;
  logic        verdict_stalls_on;
  int unsigned ready_hold = 0;

  // Frame under construction
  logic [7:0]  frame_buf[$];
  int unsigned label_plan[$];
  int unsigned udp_at, dns_at, ans_at;

  function automatic void clear_parse();
    byte_pos   = 0;
    ip_hdr_len = 0;
    next_label = DNS_QUESTION;
    answer_pos = 0;
    rejected   = 1'b0;
    decided    = ST_IGNORED;
    last_two   = '0;
    an_count   = '0;
    rr_type    = '0;
    rr_class   = '0;
    rr_len     = '0;
    addr_acc   = '0;
  endfunction

  function automatic void parser_reset();
    txid_reg   = TXID_RESET;
    server_reg = SERVER_ADDR_RESET;
    cport_reg  = CLIENT_PORT_RESET;
    sport_reg  = SERVER_PORT_RESET;
    clear_parse();
  endfunction

  // Position-driven parse of one byte; mirrors the block's single pass.
  function automatic void parse_one(int unsigned idx, logic [7:0] b);
    int unsigned udp, rel, nq, a;
    last_two = {last_two[7:0], b};
    if (rejected || decided != ST_IGNORED) return;

    if (idx == ETH_TYPE_LO && last_two != ETHERTYPE_IPV4) begin
      rejected = 1'b1;
      return;
    end
    if (idx == ETH_HDR) begin
      ip_hdr_len = 32'(b[3:0]) << 2;
      if (ip_hdr_len < MIN_IP_HDR) rejected = 1'b1;
      return;
    end
    if (idx < ETH_HDR) return;
    if (idx == IP_PROTO && b != PROTO_UDP) begin
      rejected = 1'b1;
      return;
    end
    if (idx >= IP_SRC && idx <= IP_SRC + 3) begin
      if (server_reg[31 - 8 * (idx - IP_SRC) -: 8] != b) rejected = 1'b1;
      return;
    end

    // UDP header sits right after the variable-length IP header
    udp = ETH_HDR + ip_hdr_len;
    if (idx == udp + 1 && last_two != sport_reg) begin
      rejected = 1'b1;
      return;
    end
    if (idx == udp + 3 && last_two != cport_reg) begin
      rejected = 1'b1;
      return;
    end
    if (idx < udp + 8) return;
    rel = idx - (udp + 8);

    if (rel == DNS_TXID_LO) begin
      if (last_two != txid_reg) rejected = 1'b1;
      return;
    end
    if (rel == DNS_ANCNT_LO) begin
      an_count = last_two;
      if (an_count == 0) decided = ST_NO_ANSWER;
      return;
    end

    // Question walk: hop label to label, capped at QUESTION_LIMIT
    if (answer_pos == 0) begin
      if (rel == next_label) begin
        if (b == 0) begin
          answer_pos = next_label + 5;
        end else begin
          nq = next_label + b + 1;
          if (nq >= QUESTION_LIMIT) answer_pos = nq + 5;
          else next_label = nq;
        end
      end
      return;
    end

    a = answer_pos;
    if (rel == a) begin
      if (b != POINTER_BYTE) decided = ST_NOT_POINTER;
    end else if (rel == a + 3) begin
      rr_type = last_two;
    end else if (rel == a + 5) begin
      rr_class = last_two;
    end else if (rel == a + 11) begin
      rr_len = last_two;
      if (!(rr_type == TYPE_A && rr_class == CLASS_IN && rr_len == A_RDLEN))
        decided = ST_NOT_A;
    end else if (rel >= a + 12 && rel <= a + 15) begin
      addr_acc = {addr_acc[23:0], b};
      if (rel == a + 15) decided = ST_RESOLVED;
    end
  endfunction

  // Called on every accepted byte; queues a verdict on the last one.
  function automatic void track_byte(logic [7:0] b, logic last);
    verdict_t v;
    parse_one(byte_pos, b);
    if (last) begin
      v.status  = (rejected || byte_pos + 1 < MIN_FRAME_BYTES) ? ST_IGNORED : decided;
      v.address = (v.status == ST_RESOLVED) ? addr_acc : '0;
      expected_verdicts.push_back(v);
      clear_parse();
    end else if (byte_pos >= MAX_FRAME_BYTES - 1) begin
      rejected = 1'b1;   // counter saturates, frame is oversize
    end else begin
      byte_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Frame construction
  // ---------------------------------------------------------------------
  // Mostly back-to-back, sometimes a few cycles, rarely a long hole.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic reply_t random_reply();
    reply_t r;
    r.ihl       = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : MIN_IHL_WORDS;
    r.ancount   = 16'($urandom_range(1, 65535));
    r.name_byte = POINTER_BYTE;
    r.rtype     = TYPE_A;
    r.rclass    = CLASS_IN;
    r.rdlen     = A_RDLEN;
    r.addr      = $urandom;
    r.n_labels  = $urandom_range(0, 4);
    r.max_label = ($urandom_range(0, 4) == 0) ? 255 : 20;
    r.tail      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    return r;
  endfunction

  function automatic void push_random(int unsigned n);
    repeat (n) frame_buf.push_back(8'($urandom));
  endfunction

  function automatic void push_word(logic [15:0] w);
    frame_buf.push_back(w[15:8]);
    frame_buf.push_back(w[7:0]);
  endfunction

  function automatic void trim_frame(int unsigned n);
    while (frame_buf.size() > n) frame_buf.pop_back();
  endfunction

  // Flip at least one bit of a byte so the field no longer matches.
  function automatic void flip_byte(int unsigned at);
    frame_buf[at] ^= 8'($urandom_range(1, 255));
  endfunction

  // Build a reply addressed per the current register copies. Labels come
  // from label_plan when it is set, otherwise random. The answer goes where
  // the parser expects it, including after the question-walk cap.
  function automatic void build_reply(reply_t r);
    int unsigned hdr, q, nq;
    int unsigned lens[$];
    logic        capped;
    frame_buf.delete();
    push_random(12);                              // MACs
    push_word(ETHERTYPE_IPV4);
    frame_buf.push_back({4'($urandom), r.ihl});   // version nibble is don't-care
    push_random(8);
    frame_buf.push_back(PROTO_UDP);
    push_random(2);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(server_reg[8 * i +: 8]);
    push_random(4);                               // destination IP
    hdr = (r.ihl >= MIN_IHL_WORDS) ? 4 * r.ihl : MIN_IP_HDR;
    push_random(hdr - MIN_IP_HDR);                // IP options

    udp_at = frame_buf.size();
    push_word(sport_reg);
    push_word(cport_reg);
    push_random(4);

    dns_at = frame_buf.size();
    push_word(txid_reg);
    push_random(4);                               // flags, qdcount
    push_word(r.ancount);
    push_random(4);

    if (label_plan.size() != 0) begin
      lens = label_plan;
      label_plan.delete();
    end else begin
      repeat (r.n_labels) lens.push_back($urandom_range(1, r.max_label));
    end
    q = DNS_QUESTION;
    capped = 1'b0;
    foreach (lens[i]) if (!capped) begin
      frame_buf.push_back(8'(lens[i]));
      push_random(lens[i]);
      nq = q + lens[i] + 1;
      if (nq >= QUESTION_LIMIT) capped = 1'b1;
      else q = nq;
    end
    if (capped) begin
      push_random(5);
    end else begin
      frame_buf.push_back(8'h00);                 // root label
      push_word(TYPE_A);
      push_word(CLASS_IN);
    end

    ans_at = frame_buf.size();
    frame_buf.push_back(r.name_byte);
    frame_buf.push_back(8'h0C);                   // pointer to the question
    push_word(r.rtype);
    push_word(r.rclass);
    push_random(4);                               // TTL
    push_word(r.rdlen);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(r.addr[8 * i +: 8]);
    while (frame_buf.size() < MIN_FRAME_BYTES) push_random(1);
    push_random(r.tail);
  endfunction

  function automatic void make_frame(reply_t r, defect_t d);
    if (d == DEF_SHORT_IHL) r.ihl = 4'($urandom_range(0, MIN_IHL_WORDS - 1));
    if (d == DEF_NO_ANSWER) r.ancount = '0;
    if (d == DEF_NAME) r.name_byte = POINTER_BYTE ^ 8'($urandom_range(1, 255));
    build_reply(r);
    case (d)
      DEF_ETHERTYPE: flip_byte(ETH_TYPE_HI + $urandom_range(0, 1));
      DEF_PROTO:     flip_byte(IP_PROTO);
      DEF_SOURCE:    flip_byte(IP_SRC + $urandom_range(0, 3));
      DEF_SPORT:     flip_byte(udp_at + $urandom_range(0, 1));
      DEF_DPORT:     flip_byte(udp_at + 2 + $urandom_range(0, 1));
      DEF_TXID:      flip_byte(dns_at + $urandom_range(0, 1));
      DEF_TYPE:      flip_byte(ans_at + 2 + $urandom_range(0, 1));
      DEF_CLASS:     flip_byte(ans_at + 4 + $urandom_range(0, 1));
      DEF_RDLEN:     flip_byte(ans_at + 10 + $urandom_range(0, 1));
      // end anywhere before the last address byte: never decided
      DEF_EARLY_END: trim_frame($urandom_range(1, ans_at + 15));
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  // valid is only lowered when a gap is taken, so back-to-back bytes never
  // see a low and a high in the same step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = rx_gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid      <= 1'b1;
    rx.rx_byte    <= b;
    rx.frame_last <= last;
    do @(posedge clk); while (rx.ready !== 1'b1);
    track_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Hold the input idle until every queued verdict has been taken.
  task automatic hold_until_drained();
    rx.valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  // Every frame ends in a verdict, so an empty queue plus the pipeline
  // depth (input reg + output reg) means the block is idle.
  task automatic wait_idle();
    hold_until_drained();
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers back to back; upper bits of the 16-bit
  // registers carry junk that the block must drop.
  task automatic set_regs(input logic [15:0] txid, input logic [31:0] server,
                          input logic [15:0] cport, input logic [15:0] sport);
    reg_index_t  idx_list[4];
    logic [31:0] val_list[4];
    idx_list = '{REG_EXPECTED_TXID, REG_SERVER_ADDRESS, REG_CLIENT_PORT, REG_SERVER_PORT};
    val_list = '{{16'($urandom), txid}, server, {16'($urandom), cport},
                 {16'($urandom), sport}};
    wait_idle();
    foreach (idx_list[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    txid_reg   = txid;
    server_reg = server;
    cport_reg  = cport;
    sport_reg  = sport;
  endtask

  // Verdict backpressure: random holds, or always ready when stalls are off.
  always @(posedge clk) begin
    if (rst || !verdict_stalls_on) begin
      verdict.ready <= 1'b1;
    end else if (ready_hold != 0) begin
      verdict.ready <= 1'b0;
      ready_hold--;
    end else begin
      verdict.ready <= 1'b1;
      ready_hold = idle_len();
    end
  end

  // Verdict checker: oldest expectation first, field by field.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && verdict.valid === 1'b1 && verdict.ready === 1'b1) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected verdict: status %0d address %h",
               verdict.status, verdict.resolved_address);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, verdict.status);
          mismatches++;
        end
        if (verdict.resolved_address !== want.address) begin
          $error("resolved_address: expected %h, got %h",
                 want.address, verdict.resolved_address);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Reset register values, address extremes, junk after the verdict.
  task automatic test_reset_registers();
    reply_t r;
    r = random_reply();
    r.addr = '0;
    make_frame(r, DEF_NONE);
    send_frame();
    r = random_reply();
    r.addr = '1;
    r.tail = 30;
    make_frame(r, DEF_NONE);
    send_frame();
  endtask

  // Each header filter on its own.
  task automatic test_header_filters();
    defect_t list[6];
    list = '{DEF_ETHERTYPE, DEF_PROTO, DEF_SOURCE, DEF_SPORT, DEF_DPORT, DEF_TXID};
    foreach (list[i]) begin
      make_frame(random_reply(), list[i]);
      send_frame();
    end
  endtask

  // Largest IP header with options, and headers below 20 bytes.
  task automatic test_ip_header_length();
    reply_t r;
    r = random_reply();
    r.ihl = 4'hF;
    make_frame(r, DEF_NONE);
    send_frame();
    r = random_reply();
    r.ihl = 4'h0;
    make_frame(r, DEF_NONE);
    send_frame();
    make_frame(random_reply(), DEF_SHORT_IHL);
    send_frame();
  endtask

  // Every non-resolved answer verdict.
  task automatic test_answer_checks();
    defect_t list[5];
    list = '{DEF_NO_ANSWER, DEF_NAME, DEF_TYPE, DEF_CLASS, DEF_RDLEN};
    foreach (list[i]) begin
      make_frame(random_reply(), list[i]);
      send_frame();
    end
  endtask

  // Question walk: exactly at the cap, one short of it, well past it, empty.
  task automatic test_question_walk();
    reply_t r;
    r = random_reply();
    label_plan = '{255, 31};        // 12 + 256 + 32 lands on the cap
    make_frame(r, DEF_NONE);
    send_frame();
    label_plan = '{255, 30};        // terminator read one before the cap
    make_frame(r, DEF_NONE);
    send_frame();
    label_plan = '{63, 63, 63, 63, 63, 63};
    make_frame(r, DEF_NONE);
    send_frame();
    r.n_labels = 0;                 // root name only
    make_frame(r, DEF_NONE);
    send_frame();
  endtask

  // Early end, minimum-length edge, one-byte frame.
  task automatic test_short_frames();
    reply_t r;
    make_frame(random_reply(), DEF_EARLY_END);
    send_frame();
    // no-answer verdict is decided early; only the length decides
    r = random_reply();
    r.ihl = MIN_IHL_WORDS;
    make_frame(r, DEF_NO_ANSWER);
    trim_frame(MIN_FRAME_BYTES - 1);
    send_frame();
    make_frame(r, DEF_NO_ANSWER);
    trim_frame(MIN_FRAME_BYTES);
    send_frame();
    frame_buf = '{8'($urandom)};
    send_frame();
  endtask

  // Largest legal frame, then one and many bytes past it.
  task automatic test_frame_size_limit();
    int unsigned sizes[3];
    sizes = '{MAX_FRAME_BYTES, MAX_FRAME_BYTES + 1, MAX_FRAME_BYTES + 60};
    rx_gaps_on = 1'b0;              // also a long stretch with no idling
    verdict_stalls_on = 1'b0;
    foreach (sizes[i]) begin
      make_frame(random_reply(), DEF_NONE);
      while (frame_buf.size() < sizes[i]) push_random(1);
      send_frame();
    end
    rx_gaps_on = 1'b1;
    verdict_stalls_on = 1'b1;
  endtask

  // All-zero and all-one register settings.
  task automatic test_register_extremes();
    set_regs('0, '0, '0, '0);
    make_frame(random_reply(), DEF_NONE);
    send_frame();
    make_frame(random_reply(), DEF_SPORT);
    send_frame();
    set_regs('1, '1, '1, '1);
    make_frame(random_reply(), DEF_NONE);
    send_frame();
    make_frame(random_reply(), DEF_TXID);
    send_frame();
  endtask

  // Mostly well-formed replies with random content, some single defects,
  // some pure noise of random length.
  task automatic test_random_traffic();
    int unsigned pick;
    for (int phase = 0; phase < 3; phase++) begin
      set_regs(16'($urandom), $urandom, 16'($urandom), 16'($urandom));
      for (int f = 0; f < 20; f++) begin
        rx_gaps_on = ($urandom_range(0, 4) != 0);
        verdict_stalls_on = ($urandom_range(0, 4) != 0);
        if (f == 10) hold_until_drained();
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          make_frame(random_reply(), DEF_NONE);
        end else if (pick < 85) begin
          make_frame(random_reply(), defect_t'($urandom_range(DEF_ETHERTYPE, DEF_EARLY_END)));
        end else begin
          frame_buf.delete();
          push_random($urandom_range(1, 100));
        end
        send_frame();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_EXPECTED_TXID;
    cfg_data          = '0;
    rx.valid          = 1'b0;
    rx.rx_byte        = '0;
    rx.frame_last     = 1'b0;
    verdict.ready     = 1'b0;
    rx_gaps_on        = 1'b1;
    verdict_stalls_on = 1'b1;
    parser_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_registers();
    test_header_filters();
    test_ip_header_length();
    test_answer_checks();
    test_question_walk();
    test_short_frames();
    test_frame_size_limit();
    test_register_extremes();
    test_random_traffic();

    // Drain, bounded, then let any stray verdict show up.
    rx.valid <= 1'b0;
    for (int i = 0; i < 2000 && expected_verdicts.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (expected_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", expected_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("dns_a_response_parser regression: pass");
    end else begin
      $display("dns_a_response_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("dns_a_response_parser regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/dnsa_pkg.sv
rtl/dnsa_if.sv
rtl/dns_a_response_parser.sv
tb/tb_top.sv
